// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aria_pkg.sv =====
package aria_pkg;

    localparam int ROUND_KEYS = 13;
    localparam int RK_IDX_W   = 4;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW  = 1'b1;
    localparam int         CFG_IDX_W    = 1;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } aria_in_t;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } aria_out_t;

    localparam logic [127:0] CK1 = 128'h517cc1b727220a94fe13abe8fa9a6ee0;
    localparam logic [127:0] CK2 = 128'h6db14acc9e21c820ff28b1d5ef5de2b0;
    localparam logic [127:0] CK3 = 128'hdb92371d2126e9700324977504e8c90e;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x = {1'b0, a};
        acc = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8])
                x = x ^ 9'h11b;
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_pow(input logic [7:0] a, input int e);
        logic [7:0] r;
        logic [7:0] base;
        r = 8'h01;
        base = a;
        for (int i = 0; i < 8; i++)
        begin
            if (e[i])
                r = gf_mul(r, base);
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] s1_fn(input logic [7:0] x);
        logic [7:0] inv;
        inv = gf_pow(x, 254);
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
            ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [7:0] s2_fn(input logic [7:0] x);
        logic [7:0] p;
        logic [7:0] rows [8];
        logic [7:0] s;
        rows = '{8'h7a, 8'hbc, 8'heb, 8'hb9, 8'h34, 8'h81, 8'hba, 8'hcb};
        p = gf_pow(x, 247);
        for (int i = 0; i < 8; i++)
            s[i] = ^(rows[i] & p);
        return s ^ 8'he2;
    endfunction

    typedef logic [7:0] sbox_t [256];

    function automatic sbox_t build_box(input int which);
        sbox_t t;
        logic [7:0] v;
        for (int x = 0; x < 256; x++)
        begin
            case (which)
                0: t[x] = s1_fn(x[7:0]);
                1: t[x] = s2_fn(x[7:0]);
                2:
                begin
                    v = s1_fn(x[7:0]);
                    t[v] = x[7:0];
                end
                default:
                begin
                    v = s2_fn(x[7:0]);
                    t[v] = x[7:0];
                end
            endcase
        end
        return t;
    endfunction

    localparam sbox_t SB1  = build_box(0);
    localparam sbox_t SB2  = build_box(1);
    localparam sbox_t SB1I = build_box(2);
    localparam sbox_t SB2I = build_box(3);

    // byte i of the block is bits 127-8i .. 120-8i
    function automatic logic [7:0] byte_of(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] diffuse(input logic [127:0] b);
        logic [7:0] x [16];
        logic [7:0] t [16];
        for (int i = 0; i < 16; i++)
            x[i] = byte_of(b, i);
        t[0]  = x[3] ^ x[4] ^ x[6] ^ x[8]  ^ x[9]  ^ x[13] ^ x[14];
        t[1]  = x[2] ^ x[5] ^ x[7] ^ x[8]  ^ x[9]  ^ x[12] ^ x[15];
        t[2]  = x[1] ^ x[4] ^ x[6] ^ x[10] ^ x[11] ^ x[12] ^ x[15];
        t[3]  = x[0] ^ x[5] ^ x[7] ^ x[10] ^ x[11] ^ x[13] ^ x[14];
        t[4]  = x[0] ^ x[2] ^ x[5] ^ x[8]  ^ x[11] ^ x[14] ^ x[15];
        t[5]  = x[1] ^ x[3] ^ x[4] ^ x[9]  ^ x[10] ^ x[14] ^ x[15];
        t[6]  = x[0] ^ x[2] ^ x[7] ^ x[9]  ^ x[10] ^ x[12] ^ x[13];
        t[7]  = x[1] ^ x[3] ^ x[6] ^ x[8]  ^ x[11] ^ x[12] ^ x[13];
        t[8]  = x[0] ^ x[1] ^ x[4] ^ x[7]  ^ x[10] ^ x[13] ^ x[15];
        t[9]  = x[0] ^ x[1] ^ x[5] ^ x[6]  ^ x[11] ^ x[12] ^ x[14];
        t[10] = x[2] ^ x[3] ^ x[5] ^ x[6]  ^ x[8]  ^ x[13] ^ x[15];
        t[11] = x[2] ^ x[3] ^ x[4] ^ x[7]  ^ x[9]  ^ x[12] ^ x[14];
        t[12] = x[1] ^ x[2] ^ x[6] ^ x[7]  ^ x[9]  ^ x[11] ^ x[12];
        t[13] = x[0] ^ x[3] ^ x[6] ^ x[7]  ^ x[8]  ^ x[10] ^ x[13];
        t[14] = x[0] ^ x[3] ^ x[4] ^ x[5]  ^ x[9]  ^ x[11] ^ x[14];
        t[15] = x[1] ^ x[2] ^ x[4] ^ x[5]  ^ x[8]  ^ x[10] ^ x[15];
        return {t[0], t[1], t[2], t[3], t[4], t[5], t[6], t[7],
                t[8], t[9], t[10], t[11], t[12], t[13], t[14], t[15]};
    endfunction

endpackage

// ===== src/aria128_block_cipher_unit.sv =====
// ARIA-128 encrypt/decrypt engine.
// Input channel in_valid/in_stall/in_data transfers one block with its kind
// (0 encrypt, 1 decrypt); output channel out_valid/out_stall/out_data
// transfers the 128-bit result. The key is written through cfg_we/cfg_index/
// cfg_data (index 0 upper half, 1 lower half); the user must see that it is
// written only while the engine is idle, as the block does not enforce this.
// After a key write the next block first runs the key schedule: 3 FO/FE
// rounds on the shared round datapath and 13 round-key writes into the key
// store. A block then runs a key-fetch state and its rounds (11 full rounds,
// the final substitution, the whitening) on the shared round unit, one store
// read per cycle. A new block is taken only when the sequencer is idle.
// The result sits in an output register, so the next block can be taken and
// processed while it waits; that block holds in its last round cycle until
// the register is free.
// Reset clears the key registers and the keys-ready flag, returns the
// sequencer to idle and drops out_valid. While out_stall is high the
// result holds and in_stall rises once the next block is taken.
`include "assert_macros.svh"
module aria128_block_cipher_unit
    import aria_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  aria_in_t        in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output aria_out_t       out_data,
    input  logic            cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]     cfg_data
);
    typedef enum logic [2:0] {ST_IDLE, ST_KS, ST_KW, ST_FETCH, ST_RUN} state_t;

    state_t               state_reg;
    logic [63:0]          key_high_reg, key_low_reg;
    logic                 keys_ready_reg;
    logic                 dec_reg;
    logic [127:0]         blk_reg;
    logic [127:0]         w0_reg, w1_reg, w2_reg, w3_reg;
    logic [RK_IDX_W-1:0]  cnt_reg;
    aria_out_t            out_reg;
    logic                 out_valid_reg;

    logic                 in_xfer, out_xfer, post_result;
    logic [127:0]         rnd_in, rnd_key, rnd_sub, rnd_out;
    logic                 rnd_odd;
    logic [127:0]         rk_rdata, rk_wdata, rk_used;
    logic [RK_IDX_W-1:0]  rk_raddr, rk_idx_next;
    logic [127:0]         wa, wb, rot;
    logic [6:0]           rot_n;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // last round cycle posts the result once the output register is free
    assign post_result = (state_reg == ST_RUN) && (cnt_reg == 4'(ROUND_KEYS - 1))
                         && (!out_valid_reg || out_xfer);

    // shared round unit: key-schedule rounds and cipher rounds
    always_comb
    begin
        rnd_in  = blk_reg;
        rnd_key = rk_used;
        rnd_odd = (cnt_reg[0] == 1'b0);
        if (state_reg == ST_KS)
        begin
            case (cnt_reg)
                4'd0:
                begin
                    rnd_in = w0_reg; rnd_key = CK1; rnd_odd = 1'b1;
                end
                4'd1:
                begin
                    rnd_in = w1_reg; rnd_key = CK2; rnd_odd = 1'b0;
                end
                default:
                begin
                    rnd_in = w2_reg; rnd_key = CK3; rnd_odd = 1'b1;
                end
            endcase
        end
        else if (cnt_reg == 4'(ROUND_KEYS - 2))
            rnd_odd = 1'b0;
    end

    aria_round u_round (
        .din     (rnd_in),
        .rkey    (rnd_key),
        .odd     (rnd_odd),
        .sub_out (rnd_sub),
        .dout    (rnd_out)
    );

    // decryption takes keys in reverse, middle ones diffused
    always_comb
    begin
        rk_used = rk_rdata;
        if (dec_reg && (cnt_reg != 4'd0) && (cnt_reg != 4'(ROUND_KEYS - 1)))
            rk_used = diffuse(rk_rdata);
    end

    // round key k = W[k%4] ^ rotl(W[(k+1)%4], amount of group k/4)
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin wa = w0_reg; wb = w1_reg; end
            2'd1:    begin wa = w1_reg; wb = w2_reg; end
            2'd2:    begin wa = w2_reg; wb = w3_reg; end
            default: begin wa = w3_reg; wb = w0_reg; end
        endcase
        case (cnt_reg[3:2])
            2'd0:    rot_n = 7'd109;
            2'd1:    rot_n = 7'd97;
            2'd2:    rot_n = 7'd61;
            default: rot_n = 7'd31;
        endcase
        rot = (wb << rot_n) | (wb >> (8'd128 - {1'b0, rot_n}));
        rk_wdata = wa ^ rot;
    end

    // read address for the next round, registered in the store ahead of use;
    // the whitening key is read again while the last round cycle holds
    always_comb
    begin
        if (state_reg == ST_FETCH)
            rk_idx_next = 4'd0;
        else if (state_reg == ST_RUN)
            rk_idx_next = (cnt_reg == 4'(ROUND_KEYS - 1)) ? cnt_reg : cnt_reg + 4'd1;
        else
            rk_idx_next = 4'd0;
        rk_raddr = dec_reg ? 4'(ROUND_KEYS - 1) - rk_idx_next : rk_idx_next;
    end

    aria_rk_store #(
        .WIDTH (128),
        .DEPTH (ROUND_KEYS)
    ) u_store (
        .clk   (clk),
        .we    (state_reg == ST_KW),
        .waddr (cnt_reg),
        .wdata (rk_wdata),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            cnt_reg        <= '0;
            dec_reg        <= 1'b0;
            blk_reg        <= '0;
            w0_reg         <= '0;
            w1_reg         <= '0;
            w2_reg         <= '0;
            w3_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_HIGH:
                    begin
                        key_high_reg   <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    CFG_KEY_LOW:
                    begin
                        key_low_reg    <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (post_result)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        blk_reg <= {in_data.block_high, in_data.block_low};
                        dec_reg <= in_data.kind;
                        cnt_reg <= '0;
                        if (keys_ready_reg)
                            state_reg <= ST_FETCH;
                        else
                        begin
                            w0_reg    <= {key_high_reg, key_low_reg};
                            state_reg <= ST_KS;
                        end
                    end
                end
                ST_KS:
                begin
                    case (cnt_reg)
                        4'd0: w1_reg <= rnd_out;
                        4'd1: w2_reg <= rnd_out ^ w0_reg;
                        default: w3_reg <= rnd_out ^ w1_reg;
                    endcase
                    if (cnt_reg == 4'd2)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_KW;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                ST_KW:
                begin
                    if (cnt_reg == 4'(ROUND_KEYS - 1))
                    begin
                        cnt_reg        <= '0;
                        keys_ready_reg <= 1'b1;
                        state_reg      <= ST_FETCH;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                ST_FETCH:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (cnt_reg == 4'(ROUND_KEYS - 2))
                    begin
                        blk_reg <= rnd_sub;
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                    else if (cnt_reg == 4'(ROUND_KEYS - 1))
                    begin
                        // hold here while the previous result still waits
                        if (post_result)
                        begin
                            out_reg   <= blk_reg ^ rk_used;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        blk_reg <= rnd_out;
                        cnt_reg <= cnt_reg + 4'd1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_no_accept_busy, clk, rst_n,
        !(in_xfer && (state_reg != ST_IDLE)), "block accepted while busy")
    `ASSERT_NEXT(a_result_after_run, clk, rst_n,
        (state_reg == ST_RUN) && (cnt_reg == 4'(ROUND_KEYS - 1)),
        out_valid_reg, "result not posted after last round")
    `ASSERT_CLK(a_run_needs_keys, clk, rst_n,
        !((state_reg == ST_RUN) && !keys_ready_reg), "rounds without round keys")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && out_stall,
        out_valid_reg && $stable(out_reg), "stalled result changed")

endmodule

// ===== src/aria_sub_lane.sv =====
// One byte lane: key add and substitution through the box chosen by lane and round parity
module aria_sub_lane
    import aria_pkg::*;
(
    input  logic [1:0] lane_pos,
    input  logic       odd,
    input  logic [7:0] din,
    input  logic [7:0] kin,
    output logic [7:0] dout
);
    logic [1:0] sel;
    logic [7:0] x;

    assign sel = odd ? lane_pos : (lane_pos ^ 2'd2);
    assign x   = din ^ kin;

    always_comb
    begin
        case (sel)
            2'd0:    dout = SB1[x];
            2'd1:    dout = SB2[x];
            2'd2:    dout = SB1I[x];
            default: dout = SB2I[x];
        endcase
    end
endmodule

// ===== src/aria_round.sv =====
// Sixteen lanes side by side, then the merging diffusion layer
module aria_round
    import aria_pkg::*;
(
    input  logic [127:0] din,
    input  logic [127:0] rkey,
    input  logic         odd,
    output logic [127:0] sub_out,
    output logic [127:0] dout
);
    genvar g;
    generate
        for (g = 0; g < 16; g++)
        begin : g_lane
            aria_sub_lane u_lane (
                .lane_pos (2'(g % 4)),
                .odd      (odd),
                .din      (din[127 - 8 * g -: 8]),
                .kin      (rkey[127 - 8 * g -: 8]),
                .dout     (sub_out[127 - 8 * g -: 8])
            );
        end
    endgenerate

    assign dout = diffuse(sub_out);
endmodule

// ===== src/aria_rk_store.sv =====
// Generic single-port-write RAM with registered read
module aria_rk_store #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 13,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
